// ===== hw/rtl/tcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Shared item types, controller/datapath command and status groups, and the
// character, mode and reset constants of the console.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Item modes.
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Character codes and reset values.
    localparam logic [7:0]  CH_NEWLINE  = 8'd10;
    localparam logic [7:0]  CH_SPACE    = 8'd32;
    localparam logic [7:0]  COLOR_RESET = 8'h07;
    localparam logic [15:0] CELL_RESET  = {COLOR_RESET, CH_SPACE};

    // One input item.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the incoming item
        logic exec;       // carry out the captured item
        logic fill_step;  // write one cell of the running fill
        logic load_out;   // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_fill;  // the item being executed starts a fill
        logic fill_last;  // the current fill step writes the last cell
        logic out_busy;   // the result register holds an item not taken now
    } t_dp_status;

endpackage
`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the reset clearing pass, item execution, row and screen fills,
// and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_cmd       o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_EXEC = 5'b00100,
        S_FILL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_stall      = 1'b1;
        case (r_state)
            S_INIT: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_fill ? S_FILL : S_DONE;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tcw_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer datapath
// Holds the cell memory, cursor, scroll offset, fill counters, color
// register and result register. Rows are kept in a ring: scrolling moves
// the top row pointer and refills only the row that becomes the bottom.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wr_en,
    input  wire  [7:0]             i_cfg_wr_data,
    input  wire tcw_pkg::t_in_item i_in_data,
    input  wire tcw_pkg::t_dp_cmd  i_cmd,
    output tcw_pkg::t_dp_status    o_status,
    input  wire                    i_out_stall,
    output logic                   o_out_valid,
    output tcw_pkg::t_out_item     o_out_data
);
    import tcw_pkg::*;

    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = ROWS * (2 ** COL_W);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [ROW_W:0]   ROWS_X   = (ROW_W + 1)'(ROWS);
    localparam logic [7:0]       ROWS_8   = 8'(ROWS);
    localparam logic [7:0]       COLS_8   = 8'(COLUMNS);

    logic [15:0]      mem [DEPTH];

    t_in_item         r_item;
    logic [7:0]       r_color;
    logic [ROW_W-1:0] r_cur_row;
    logic [COL_W-1:0] r_cur_col;
    logic [ROW_W-1:0] r_top;
    logic [ROW_W-1:0] r_fill_row;
    logic [COL_W-1:0] r_fill_col;
    logic [ROW_W-1:0] r_fill_end;
    logic [15:0]      r_fill_val;
    logic [15:0]      r_rd_data;
    logic             r_rd_hit;
    logic             r_scrolled;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic [ROW_W:0]   cur_sum;
    logic [ROW_W-1:0] cur_phys;
    logic [ROW_W:0]   rd_sum;
    logic [ROW_W-1:0] rd_phys;
    logic [ROW_W-1:0] top_next;
    logic             is_put;
    logic             is_nl;
    logic             col_wrap;
    logic             at_bottom;
    logic             do_line;
    logic             do_scroll;
    logic             do_write;
    logic             do_clear;
    logic             rd_hit;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]      mem_wdata;

    // Decode of the captured item and ring row arithmetic.
    always_comb begin
        cur_sum   = {1'b0, r_cur_row} + {1'b0, r_top};
        cur_phys  = (cur_sum >= ROWS_X) ? ROW_W'(cur_sum - ROWS_X) : ROW_W'(cur_sum);
        rd_sum    = {1'b0, ROW_W'(r_item.read_row)} + {1'b0, r_top};
        rd_phys   = (rd_sum >= ROWS_X) ? ROW_W'(rd_sum - ROWS_X) : ROW_W'(rd_sum);
        top_next  = (r_top == ROW_LAST) ? '0 : r_top + 1'b1;
        is_put    = (r_item.mode == MODE_PUT);
        is_nl     = (r_item.char_code == CH_NEWLINE);
        col_wrap  = (r_cur_col == COL_LAST);
        at_bottom = (r_cur_row == ROW_LAST);
        do_line   = is_put && (is_nl || col_wrap);
        do_scroll = do_line && at_bottom;
        do_write  = is_put && !is_nl;
        do_clear  = (r_item.mode == MODE_CLEAR);
        rd_hit    = (r_item.mode == MODE_READ)
                    && ({3'b000, r_item.read_row} < ROWS_8)
                    && ({1'b0, r_item.read_col} < COLS_8);
    end

    // Memory port selection: fills and character stores share the write port.
    always_comb begin
        mem_we    = (i_cmd.exec && do_write) || i_cmd.fill_step;
        mem_waddr = i_cmd.fill_step ? {r_fill_row, r_fill_col} : {cur_phys, r_cur_col};
        mem_wdata = i_cmd.fill_step ? r_fill_val : {r_color, r_item.char_code};
        mem_raddr = {rd_phys, COL_W'(r_item.read_col)};
    end

    // Cell memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.exec) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
    end

    // Color register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_color <= i_cfg_wr_data;
        end
    end

    // Cursor, ring offset and per-item flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_top      <= '0;
            r_rd_hit   <= 1'b0;
            r_scrolled <= 1'b0;
        end else if (i_cmd.exec) begin
            r_rd_hit   <= rd_hit;
            r_scrolled <= do_scroll;
            if (do_clear) begin
                r_cur_row <= '0;
                r_cur_col <= '0;
                r_top     <= '0;
            end else if (do_line) begin
                r_cur_col <= '0;
                if (at_bottom) begin
                    r_top <= top_next;
                end else begin
                    r_cur_row <= r_cur_row + 1'b1;
                end
            end else if (do_write) begin
                r_cur_col <= r_cur_col + 1'b1;
            end
        end
    end

    // Fill counters; reset sets up the clearing pass in the reset color.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_row <= '0;
            r_fill_col <= '0;
            r_fill_end <= ROW_LAST;
            r_fill_val <= CELL_RESET;
        end else if (i_cmd.exec) begin
            r_fill_col <= '0;
            r_fill_val <= {r_color, CH_SPACE};
            if (do_clear) begin
                r_fill_row <= '0;
                r_fill_end <= ROW_LAST;
            end else begin
                // The old top row becomes the new bottom row after a scroll.
                r_fill_row <= r_top;
                r_fill_end <= r_top;
            end
        end else if (i_cmd.fill_step) begin
            if (r_fill_col == COL_LAST) begin
                r_fill_col <= '0;
                r_fill_row <= r_fill_row + 1'b1;
            end else begin
                r_fill_col <= r_fill_col + 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.cell_data  <= r_rd_hit ? r_rd_data : '0;
            r_out_data.cursor_row <= 5'(r_cur_row);
            r_out_data.cursor_col <= 7'(r_cur_col);
            r_out_data.scrolled   <= r_scrolled;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_status.need_fill = do_scroll || do_clear;
        o_status.fill_last = (r_fill_col == COL_LAST) && (r_fill_row == r_fill_end);
        o_status.out_busy  = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ===== hw/rtl/text_console_writer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer unit
// A ROWS by COLUMNS text console: prints characters with wrap, newline and
// scrolling, clears the screen, and reads single cells for display refresh.
//
//   Channel   Direction   Handshake                      Payload
//   input     in          i_in_valid / o_in_stall        i_in_data  (t_in_item)
//   output    out         o_out_valid / i_out_stall      o_out_data (t_out_item)
//   config    in          i_cfg_wr_en                    i_cfg_wr_data (text color)
//
// A put or read item passes through capture, execute (one memory access) and
// result load. A scroll adds a refill of one row, and a clear a refill of all
// ROWS*COLUMNS cells, one cell a cycle through the single write port.
// After reset a clearing pass over all ROWS*COLUMNS cells (2000 by default) runs
// before the first item is accepted. An item is accepted while the previous
// result still waits; a held result stalls the next load, and input with it.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wr_en,
    input  wire  [7:0]             i_cfg_wr_data,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire tcw_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output tcw_pkg::t_out_item     o_out_data
);
    import tcw_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencing.
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Storage and arithmetic.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule
`default_nettype wire
